[src/smgr_pkg.sv]
// ----------------------------------------------------------------------------
// smgr_pkg: shared types and constants of the minimum-gap and range tracker
// Holds the field widths, the reset values of the running state, the
// sequencer state type and the control bundle passed between modules.
// ----------------------------------------------------------------------------
package smgr_pkg;

	localparam int DATA_W        = 32;
	localparam int CAP_W         = 11;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [CAP_W-1:0]  CAPACITY_RESET = 11'd1024;
	localparam logic [DATA_W-1:0] MIN_RESET      = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MAX_RESET      = 32'h8000_0000;
	localparam logic [DATA_W-1:0] GAP_RESET      = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_STORE,
		ST_REPORT
	} smgr_state_t;

	typedef struct packed {
		logic busy;
		logic accept;
		logic rd_en;
		logic store;
		logic report;
	} smgr_ctrl_t;

endpackage

[src/smgr_ram.sv]
// ----------------------------------------------------------------------------
// smgr_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module smgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/smgr_gap.sv]
// ----------------------------------------------------------------------------
// smgr_gap: shared distance and minimum unit
// Takes one stored value per cycle, forms its absolute distance to the
// incoming value in one stage and folds it into the smallest gap seen.
// ----------------------------------------------------------------------------
module smgr_gap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        rd_issued,
	input  logic [smgr_pkg::DATA_W-1:0] probe,
	input  logic [smgr_pkg::DATA_W-1:0] stored,
	output logic [smgr_pkg::DATA_W-1:0] best_gap,
	output logic                        pipe_busy
);

	import smgr_pkg::*;

	logic              v_s1;
	logic              v_s2;
	logic [DATA_W-1:0] gap_s2;
	logic [DATA_W-1:0] best_gap_q;
	logic [DATA_W-1:0] abs_gap;

	// The signed order picks the subtraction that cannot go negative.
	always_comb begin
		if ($signed(probe) >= $signed(stored)) begin
			abs_gap = probe - stored;
		end else begin
			abs_gap = stored - probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			best_gap_q <= GAP_RESET;
		end else begin
			v_s1 <= rd_issued;
			v_s2 <= v_s1;
			if (clear) begin
				best_gap_q <= GAP_RESET;
			end else if (v_s2 && (gap_s2 < best_gap_q)) begin
				best_gap_q <= gap_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			gap_s2 <= abs_gap;
		end
	end

	assign best_gap  = best_gap_q;
	assign pipe_busy = v_s1 | v_s2;

endmodule

[src/smgr_seq.sv]
// ----------------------------------------------------------------------------
// smgr_seq: sequencer of the tracker
// Walks any held entries one per cycle, waits for the distance unit to empty,
// stores the value if there is room and hands the result to the output register.
// ----------------------------------------------------------------------------
module smgr_seq #(
	parameter int DEPTH = smgr_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           room,
	input  logic [$clog2(DEPTH+1)-1:0]     count,
	input  logic                           out_free,
	input  logic                           pipe_busy,
	output smgr_pkg::smgr_ctrl_t           ctrl,
	output logic [$clog2(DEPTH)-1:0]       rd_addr
);

	import smgr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	smgr_state_t   state_q;
	smgr_state_t   state_d;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] count_m1;
	logic [AW-1:0] last_idx;

	// Only used while scanning, when at least one value is held.
	assign count_m1 = count - CW'(1);
	assign last_idx = count_m1[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!room) begin
						state_d = ST_REPORT;
					end else if (count == '0) begin
						state_d = ST_STORE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl        = '0;
		ctrl.busy   = (state_q != ST_IDLE);
		ctrl.accept = (state_q == ST_IDLE) && in_valid;
		ctrl.rd_en  = (state_q == ST_SCAN);
		ctrl.store  = (state_q == ST_STORE);
		ctrl.report = (state_q == ST_REPORT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + AW'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	assign rd_addr = idx_q;

endmodule

[src/set_min_gap_and_range_tracker.sv]
// ----------------------------------------------------------------------------
// set_min_gap_and_range_tracker: minimum gap and range of a bounded set
// Collects signed 32-bit values and reports, after each one, the smallest
// distance between two held values and the spread from minimum to maximum.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid / in_stall     value
//   output    out        out_valid / out_stall   accepted, span_valid,
//                                                shortest_span, longest_span,
//                                                stored_count
//   config    in         cfg_wr_en               cfg_wr_data (capacity)
//
// An accepted value that joins a store already holding values has the memory read
// port stepped through every held entry and waits for the distance unit to empty;
// then the value is written, and the result register is loaded once it is free.
// A value offered to an empty store is written without a scan, and a rejected one
// goes straight to the result register. The single memory read port and the one
// distance unit set the pace of the scan.
// Reset is asynchronous and active low and leaves an empty store with a
// capacity of 1024; the memory itself is not cleared, as only entries below
// the fill count are ever read. in_stall is high from the acceptance of a
// transaction until its result has been loaded into the output register.
//
module set_min_gap_and_range_tracker #(
	parameter int DEPTH = smgr_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [smgr_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               accepted,
	output logic                               span_valid,
	output logic [smgr_pkg::DATA_W-1:0]        shortest_span,
	output logic [smgr_pkg::DATA_W-1:0]        longest_span,
	output logic [smgr_pkg::CAP_W-1:0]         stored_count,
	input  logic                               cfg_wr_en,
	input  logic [smgr_pkg::CAP_W-1:0]         cfg_wr_data
);

	import smgr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// Wide enough for both the fill count and the capacity register.
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	smgr_ctrl_t        ctrl;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] best_gap;
	logic              pipe_busy;

	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     count_q;
	logic [DATA_W-1:0] value_q;
	logic              room_q;
	logic [DATA_W-1:0] running_min_q;
	logic [DATA_W-1:0] running_max_q;

	logic              out_valid_q;
	logic              accepted_q;
	logic              span_valid_q;
	logic [DATA_W-1:0] shortest_q;
	logic [DATA_W-1:0] longest_q;
	logic [CAP_W-1:0]  stored_count_q;

	logic [LW-1:0]     limit;
	logic              room;
	logic              out_free;
	logic              two_held;

	// The usable capacity saturates at the depth of the memory.
	always_comb begin
		if (LW'(capacity_q) > LW'(DEPTH)) begin
			limit = LW'(DEPTH);
		end else begin
			limit = LW'(capacity_q);
		end
	end

	assign room     = LW'(count_q) < limit;
	assign out_free = !out_valid_q || !out_stall;
	assign two_held = count_q >= CW'(2);

	smgr_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.room     (room),
		.count    (count_q),
		.out_free (out_free),
		.pipe_busy(pipe_busy),
		.ctrl     (ctrl),
		.rd_addr  (rd_addr)
	);

	// The value store: written once per accepted value at the fill count,
	// read one entry per cycle during the scan.
	smgr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ctrl.store),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(value_q),
		.rd_en  (ctrl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	smgr_gap u_gap (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_wr_en),
		.rd_issued(ctrl.rd_en),
		.probe    (value_q),
		.stored   (rd_data),
		.best_gap (best_gap),
		.pipe_busy(pipe_busy)
	);

	// Running state. A capacity write empties the set; the user must write it only
	// while the tracker is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= CAPACITY_RESET;
			count_q       <= '0;
			running_min_q <= MIN_RESET;
			running_max_q <= MAX_RESET;
		end else if (cfg_wr_en) begin
			capacity_q    <= cfg_wr_data;
			count_q       <= '0;
			running_min_q <= MIN_RESET;
			running_max_q <= MAX_RESET;
		end else if (ctrl.store) begin
			count_q <= count_q + CW'(1);
			if ($signed(value_q) < $signed(running_min_q)) begin
				running_min_q <= value_q;
			end
			if ($signed(value_q) > $signed(running_max_q)) begin
				running_max_q <= value_q;
			end
		end
	end

	// The offered value and whether there was room for it are captured with
	// the transaction; the store is only written when there was room.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			value_q <= value;
			room_q  <= room;
		end
	end

	// Output register: loaded when the sequencer reports, emptied when the
	// downstream side takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.report) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.report) begin
			accepted_q     <= room_q;
			span_valid_q   <= two_held;
			shortest_q     <= two_held ? best_gap : '0;
			longest_q      <= two_held ? (running_max_q - running_min_q) : '0;
			stored_count_q <= CAP_W'(count_q);
		end
	end

	assign in_stall      = ctrl.busy;
	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign span_valid    = span_valid_q;
	assign shortest_span = shortest_q;
	assign longest_span  = longest_q;
	assign stored_count  = stored_count_q;

	// The fill count never passes the memory depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= LW'(DEPTH))
		else $error("fill count beyond memory depth");

	// A store step adds exactly one value to the set.
	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.store && !cfg_wr_en) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("store step did not advance the fill count");

	// An invalid span always reports zero distances.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !span_valid) |-> (shortest_span == '0 && longest_span == '0))
		else $error("non-zero span reported with fewer than two values");

	// Loading a result returns the tracker to idle, ready for the next value.
	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.report |=> !in_stall)
		else $error("tracker still busy after presenting a result");

endmodule
